>>> hdl/sha2_pkg.sv
// ----------------------------------------------------------------------------
// SHA-2 package
// Round constants, initial vectors and helper functions shared by the engine.
// ----------------------------------------------------------------------------
package sha2_pkg;

  localparam int RoundsNarrow = 64;
  localparam int RoundsWide   = 80;

  typedef enum logic [1:0] {
    VarSha224 = 2'd0,
    VarSha256 = 2'd1,
    VarSha384 = 2'd2,
    VarSha512 = 2'd3
  } variant_t;

  localparam logic [1:0] VariantReset = 2'd1;

  localparam logic [63:0] K64 [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] IV384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };
  localparam logic [63:0] IV512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] initial_word(input logic [1:0] v, input logic [2:0] i);
    logic [63:0] r;
    unique case (v)
      VarSha224: r = {32'd0, IV384[i][31:0]};
      VarSha256: r = {32'd0, IV512[i][63:32]};
      VarSha384: r = IV384[i];
      default:   r = IV512[i];
    endcase
    return r;
  endfunction

  function automatic logic [2:0] last_index(input logic [1:0] v);
    logic [2:0] r;
    unique case (v)
      VarSha224: r = 3'd6;
      VarSha384: r = 3'd5;
      default:   r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/sha2_round.sv
// ----------------------------------------------------------------------------
// SHA-2 round unit
// One compression round and one schedule word, 32- or 64-bit arithmetic.
// ----------------------------------------------------------------------------
module sha2_round import sha2_pkg::*; (
  input  logic        wide,
  input  logic        expand,
  input  logic [63:0] w_cur,
  input  logic [63:0] w_x,
  input  logic [63:0] w_y,
  input  logic [63:0] w_9,
  input  logic [63:0] k,
  input  logic [63:0] wr_in [8],
  output logic [63:0] w_out,
  output logic [63:0] wr_out [8]
);

  function automatic logic [31:0] r32(input logic [31:0] x, input int s);
    return (x >> s) | (x << (32 - s));
  endfunction
  function automatic logic [63:0] r64(input logic [63:0] x, input int s);
    return (x >> s) | (x << (64 - s));
  endfunction

  logic [63:0] w;
  logic [63:0] a, b, c, d, e, f, g, h;
  logic [63:0] s0, s1, ch, maj, t1, t2;
  logic [31:0] w32;

  always_comb begin
    w32 = w_cur[31:0] + w_9[31:0]
        + (r32(w_x[31:0], 7) ^ r32(w_x[31:0], 18) ^ (w_x[31:0] >> 3))
        + (r32(w_y[31:0], 17) ^ r32(w_y[31:0], 19) ^ (w_y[31:0] >> 10));
    if (!expand) begin
      w = w_cur;
    end else if (wide) begin
      w = w_cur + w_9 + (r64(w_x, 1) ^ r64(w_x, 8) ^ (w_x >> 7))
        + (r64(w_y, 19) ^ r64(w_y, 61) ^ (w_y >> 6));
    end else begin
      w = {32'd0, w32};
    end
    a = wr_in[0]; b = wr_in[1]; c = wr_in[2]; d = wr_in[3];
    e = wr_in[4]; f = wr_in[5]; g = wr_in[6]; h = wr_in[7];
    if (wide) begin
      s1 = r64(e, 14) ^ r64(e, 18) ^ r64(e, 41);
      s0 = r64(a, 28) ^ r64(a, 34) ^ r64(a, 39);
    end else begin
      s1 = {32'd0, r32(e[31:0], 6) ^ r32(e[31:0], 11) ^ r32(e[31:0], 25)};
      s0 = {32'd0, r32(a[31:0], 2) ^ r32(a[31:0], 13) ^ r32(a[31:0], 22)};
    end
    ch  = (e & f) ^ (~e & g);
    maj = (a & b) ^ (a & c) ^ (b & c);
    t1  = h + s1 + ch + (wide ? k : {32'd0, k[63:32]}) + w;
    t2  = s0 + maj;
    w_out = w;
    wr_out[7] = g; wr_out[6] = f; wr_out[5] = e;
    wr_out[3] = c; wr_out[2] = b; wr_out[1] = a;
    wr_out[4] = wide ? d + t1 : {32'd0, d[31:0] + t1[31:0]};
    wr_out[0] = wide ? t1 + t2 : {32'd0, t1[31:0] + t2[31:0]};
  end

endmodule

>>> hdl/sha2_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-2 hash engine
// SHA-224/256/384/512 over a stream of 64-bit message words.
// ----------------------------------------------------------------------------
// A word is accepted in idle and absorbed one byte per cycle, pausing while a
// filled block runs, then the engine returns to idle. A full block runs 64
// (narrow) or 80 (wide) rounds and then an update step on the single shared
// round unit. A final word adds the padding bytes, one per cycle but for such
// pauses, their blocks, then one digest item per cycle while out_ready is high.
// Reset is synchronous and loads the SHA-256 variant and its initial vector.
module sha2_hash_engine import sha2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  hash_variant,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] message_word,
  input  logic [3:0]  byte_count,
  input  logic        final_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        digest_done
);

  typedef enum logic [2:0] {
    StIdle, StAbsorb, StPad, StRound, StUpdate, StOut
  } state_t;

  state_t      state;
  logic [1:0]  variant;
  logic [63:0] cv [8];
  logic [63:0] wr [8];
  logic [63:0] sw [16];
  logic [6:0]  pos;
  logic [63:0] bit_len;
  logic [6:0]  rnd;
  logic [63:0] word;
  logic [3:0]  nleft;
  logic        fin;
  logic        pad_started;
  logic        pad_len_phase;
  logic [2:0]  oidx;
  logic        after_pad;

  logic        wide;
  logic [7:0]  byte_in;
  logic [3:0]  widx;
  logic [5:0]  sh;
  logic [6:0]  blk_last;
  logic [6:0]  len_pos;
  logic [6:0]  len_off;
  logic [3:0]  ti;
  logic [63:0] sw_merged;
  logic [63:0] w_new;
  logic [63:0] wr_new [8];

  assign wide = variant[1];
  assign blk_last = wide ? 7'd127 : 7'd63;
  assign len_pos  = wide ? 7'd112 : 7'd56;
  assign len_off  = blk_last - pos;
  assign widx = wide ? pos[6:3] : pos[5:2];
  assign sh   = wide ? {~pos[2:0], 3'b000} : {1'b0, ~pos[1:0], 3'b000};
  assign ti   = rnd[3:0];

  // Padding byte: 0x80 first, zeros up to the length field, then the length.
  // The length fills the last eight bytes of the block that has room for it.
  always_comb begin
    if (state == StAbsorb) begin
      byte_in = word[63:56];
    end else if (!pad_started) begin
      byte_in = 8'h80;
    end else if (pad_len_phase && pos >= blk_last - 7'd7) begin
      byte_in = bit_len[{len_off[2:0], 3'b000} +: 8];
    end else begin
      byte_in = 8'h00;
    end
  end

  always_comb begin
    sw_merged = (sw[widx] & ~(64'hff << sh)) | ({56'd0, byte_in} << sh);
    if (!wide) sw_merged[63:32] = '0;
  end

  sha2_round u_round (
    .wide   (wide),
    .expand (rnd >= 7'd16),
    .w_cur  (sw[ti]),
    .w_x    (sw[ti + 4'd1]),
    .w_y    (sw[ti + 4'd14]),
    .w_9    (sw[ti + 4'd9]),
    .k      (K64[rnd]),
    .wr_in  (wr),
    .w_out  (w_new),
    .wr_out (wr_new)
  );

  assign in_ready  = (state == StIdle) && !cfg_valid;
  assign cfg_ready = (state == StIdle);
  assign out_valid = (state == StOut);
  assign digest_word  = cv[oidx];
  assign digest_index = oidx;
  assign digest_done  = (oidx == last_index(variant));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      variant <= VariantReset;
      for (int i = 0; i < 8; i++) begin
        cv[i] <= initial_word(VariantReset, 3'(i));
        wr[i] <= '0;
      end
      pos <= '0; bit_len <= '0; rnd <= '0; oidx <= '0;
      pad_started <= 1'b0; pad_len_phase <= 1'b0; after_pad <= 1'b0;
      nleft <= '0; fin <= 1'b0;
    end else begin
      unique case (state)
        StIdle: begin
          if (cfg_valid) begin
            variant <= hash_variant;
            for (int i = 0; i < 8; i++) cv[i] <= initial_word(hash_variant, 3'(i));
            pos <= '0; bit_len <= '0;
          end else if (in_valid) begin
            word <= message_word;
            nleft <= (byte_count > 4'd8) ? 4'd8 : byte_count;
            fin <= final_word;
            pad_started <= 1'b0; pad_len_phase <= 1'b0;
            state <= StAbsorb;
          end
        end
        StAbsorb, StPad: begin
          if (state == StAbsorb && nleft == 4'd0) begin
            state <= fin ? StPad : StIdle;
          end else begin
            sw[widx] <= sw_merged;
            if (state == StAbsorb) begin
              word <= word << 8;
              nleft <= nleft - 4'd1;
              bit_len <= bit_len + 64'd8;
            end else begin
              pad_started <= 1'b1;
              // The length goes in this block when 0x80 lands before the
              // length position, otherwise in the next block.
              if (!pad_started && pos < len_pos) pad_len_phase <= 1'b1;
              else if (pos == blk_last) pad_len_phase <= 1'b1;
            end
            if (pos == blk_last) begin
              pos <= '0;
              for (int i = 0; i < 8; i++) wr[i] <= cv[i];
              rnd <= '0;
              after_pad <= (state == StPad) && pad_len_phase;
              state <= StRound;
            end else begin
              pos <= pos + 7'd1;
            end
          end
        end
        StRound: begin
          if (rnd >= 7'd16) sw[ti] <= w_new;
          for (int i = 0; i < 8; i++) wr[i] <= wr_new[i];
          if (rnd == (wide ? 7'(RoundsWide - 1) : 7'(RoundsNarrow - 1))) begin
            state <= StUpdate;
          end
          rnd <= rnd + 7'd1;
        end
        StUpdate: begin
          rnd <= '0;
          for (int i = 0; i < 8; i++) begin
            cv[i] <= wide ? cv[i] + wr[i] : {32'd0, cv[i][31:0] + wr[i][31:0]};
          end
          oidx <= '0;
          if (after_pad) state <= StOut;
          else if (pad_started) state <= StPad;
          else state <= StAbsorb;
        end
        StOut: begin
          if (out_ready) begin
            if (digest_done) begin
              for (int i = 0; i < 8; i++) cv[i] <= initial_word(variant, 3'(i));
              pos <= '0; bit_len <= '0; after_pad <= 1'b0;
              state <= StIdle;
            end
            oidx <= oidx + 3'd1;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

>>> hdl/sha2_hash_engine_checker.sv
// ----------------------------------------------------------------------------
// SHA-2 engine port checker
// Watches the top-level ports for handshake and digest sequencing rules.
// ----------------------------------------------------------------------------
module sha2_hash_engine_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] digest_index,
  input logic       digest_done
);

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while a digest item is pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_index))
    else $error("digest item dropped while stalled");

  a_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !digest_done |=> out_valid
      && digest_index == $past(digest_index) + 3'd1)
    else $error("digest index did not advance");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && digest_done |=> !out_valid)
    else $error("digest items continue after the last one");

endmodule

bind sha2_hash_engine sha2_hash_engine_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .digest_index(digest_index), .digest_done(digest_done)
);
